[rtl/core/rpn_pkg.sv]
// Shared types and constants of the RPN integer stack calculator.
// Holds the opcode, status and sequencer state enums and the command and result words.
// No dependencies.
package rpn_pkg;

    localparam int DATA_W          = 32;
    localparam int INDEX_W         = 6;
    localparam int COUNT_W         = 7;
    localparam int ITER_W          = 5;
    localparam int STACK_DEPTH_DEF = 64;

    typedef enum logic [2:0] {
        OP_PUSH      = 3'd0,
        OP_POP       = 3'd1,
        OP_PEEK_TOP  = 3'd2,
        OP_PEEK_BOT  = 3'd3,
        OP_ADD       = 3'd4,
        OP_SUB       = 3'd5,
        OP_MUL       = 3'd6,
        OP_DIV       = 3'd7
    } opcode_t;

    typedef enum logic [2:0] {
        ST_OK      = 3'd0,
        ST_EMPTY   = 3'd1,
        ST_RANGE   = 3'd2,
        ST_FEW     = 3'd3,
        ST_DIVZERO = 3'd4,
        ST_FULL    = 3'd5
    } status_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DECODE,
        S_FETCH_R,
        S_FETCH_L,
        S_MUL,
        S_DIV,
        S_FIX,
        S_WB
    } state_t;

    typedef struct packed {
        opcode_t                    opcode;
        logic signed [DATA_W-1:0]   push_value;
        logic        [INDEX_W-1:0]  peek_index;
    } cmd_word_t;

    typedef struct packed {
        logic signed [DATA_W-1:0]   result_value;
        status_t                    status;
        logic        [COUNT_W-1:0]  stack_count;
    } res_word_t;

endpackage

[rtl/core/rpn_ram.sv]
// Generic single-write, single-read RAM with a registered read port.
// Read data holds while no read is requested. No dependencies.
module rpn_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

[rtl/core/rpn_integer_stack_calculator_top.sv]
// Top level of the RPN integer stack calculator: sequencer, shared adder and stack RAM.
// Depends on rpn_pkg and rpn_ram.
//
// The block evaluates postfix operations on a stack of signed 32-bit integers held in
// a RAM with a registered read port. It takes one command word at a time and returns
// exactly one result word for it; the next command is taken once the sequencer is
// idle, even while the previous result still waits in the output register. Push and
// every error case other than divide by zero finish in the decode state; pop, peek
// and divide by zero after one RAM read; add and subtract after both operand reads.
// All arithmetic shares the single 33-bit adder: multiply is a shift-add and divide a
// restoring division, each one bit per cycle through that adder, and divide then
// passes a fix state that sets the sign and rounding of the quotient, which rounds
// toward minus infinity. A result that is not taken stalls the sequencer.
module rpn_integer_stack_calculator_top #(
    parameter int STACK_DEPTH = rpn_pkg::STACK_DEPTH_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cmd_valid,
    output logic               cmd_ready,
    input  rpn_pkg::cmd_word_t cmd,
    output logic               res_valid,
    input  logic               res_ready,
    output rpn_pkg::res_word_t res
);

    localparam int DW     = rpn_pkg::DATA_W;
    localparam int ADDR_W = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
    localparam int CNT_W  = $clog2(STACK_DEPTH + 1);
    localparam int CMP_W  = (CNT_W > rpn_pkg::INDEX_W) ? CNT_W : rpn_pkg::INDEX_W;

    rpn_pkg::state_t    state_reg, state_next;
    rpn_pkg::cmd_word_t cmd_reg, cmd_next;
    rpn_pkg::res_word_t res_reg, res_next;
    logic               res_valid_reg, res_valid_next;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic [DW-1:0]      left_reg, left_next;
    logic [DW-1:0]      right_reg, right_next;
    logic [DW-1:0]      acc_reg, acc_next;
    logic               sign_l_reg, sign_l_next;
    logic               sign_r_reg, sign_r_next;
    logic [rpn_pkg::ITER_W-1:0] iter_reg, iter_next;

    logic               ram_we;
    logic [ADDR_W-1:0]  ram_waddr;
    logic [DW-1:0]      ram_wdata;
    logic               ram_re;
    logic [ADDR_W-1:0]  ram_raddr;
    logic [DW-1:0]      ram_rdata;

    logic [DW:0]        add_a, add_b;
    logic               add_sub;
    logic [DW+1:0]      add_sum;

    logic               res_free;
    logic               fin;
    logic [DW-1:0]      fin_value;
    rpn_pkg::status_t   fin_status;
    logic [CMP_W-1:0]   cnt_ext, idx_ext, top_addr;
    logic [DW:0]        div_shift;

    rpn_ram #(
        .WIDTH (DW),
        .DEPTH (STACK_DEPTH)
    ) u_stack_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign add_sum = {1'b0, add_a} + {1'b0, add_b ^ {(DW + 1){add_sub}}}
                     + {{(DW + 1){1'b0}}, add_sub};

    assign res_free  = !res_valid_reg || res_ready;
    assign cnt_ext   = CMP_W'(count_reg);
    assign idx_ext   = CMP_W'(cmd_reg.peek_index);
    assign top_addr  = cnt_ext - idx_ext - CMP_W'(1);
    assign div_shift = {acc_reg, left_reg[DW-1]};

    assign cmd_ready = (state_reg == rpn_pkg::S_IDLE);
    assign res_valid = res_valid_reg;
    assign res       = res_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= rpn_pkg::S_IDLE;
            res_valid_reg <= 1'b0;
            count_reg     <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            res_valid_reg <= res_valid_next;
            count_reg     <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg    <= cmd_next;
        res_reg    <= res_next;
        left_reg   <= left_next;
        right_reg  <= right_next;
        acc_reg    <= acc_next;
        sign_l_reg <= sign_l_next;
        sign_r_reg <= sign_r_next;
        iter_reg   <= iter_next;
    end

    always_comb
    begin
        state_next     = state_reg;
        cmd_next       = cmd_reg;
        res_next       = res_reg;
        res_valid_next = res_valid_reg;
        count_next     = count_reg;
        left_next      = left_reg;
        right_next     = right_reg;
        acc_next       = acc_reg;
        sign_l_next    = sign_l_reg;
        sign_r_next    = sign_r_reg;
        iter_next      = iter_reg;
        ram_we         = 1'b0;
        ram_waddr      = '0;
        ram_wdata      = '0;
        ram_re         = 1'b0;
        ram_raddr      = '0;
        add_a          = '0;
        add_b          = '0;
        add_sub        = 1'b0;
        fin            = 1'b0;
        fin_value      = '0;
        fin_status     = rpn_pkg::ST_OK;

        case (state_reg)
            rpn_pkg::S_IDLE:
            begin
                if (cmd_valid)
                begin
                    cmd_next   = cmd;
                    state_next = rpn_pkg::S_DECODE;
                end
            end

            rpn_pkg::S_DECODE:
            begin
                case (cmd_reg.opcode)
                    rpn_pkg::OP_PUSH:
                    begin
                        fin = 1'b1;
                        if (count_reg == CNT_W'(STACK_DEPTH))
                        begin
                            fin_status = rpn_pkg::ST_FULL;
                        end
                        else if (res_free)
                        begin
                            ram_we     = 1'b1;
                            ram_waddr  = count_reg[ADDR_W-1:0];
                            ram_wdata  = cmd_reg.push_value;
                            count_next = count_reg + CNT_W'(1);
                        end
                    end
                    rpn_pkg::OP_POP:
                    begin
                        if (count_reg == '0)
                        begin
                            fin        = 1'b1;
                            fin_status = rpn_pkg::ST_EMPTY;
                        end
                        else
                        begin
                            ram_re     = 1'b1;
                            ram_raddr  = ADDR_W'(count_reg - CNT_W'(1));
                            state_next = rpn_pkg::S_FETCH_R;
                        end
                    end
                    rpn_pkg::OP_PEEK_TOP, rpn_pkg::OP_PEEK_BOT:
                    begin
                        if (idx_ext >= cnt_ext)
                        begin
                            fin        = 1'b1;
                            fin_status = rpn_pkg::ST_RANGE;
                        end
                        else
                        begin
                            ram_re     = 1'b1;
                            ram_raddr  = (cmd_reg.opcode == rpn_pkg::OP_PEEK_TOP) ?
                                         top_addr[ADDR_W-1:0] : idx_ext[ADDR_W-1:0];
                            state_next = rpn_pkg::S_FETCH_R;
                        end
                    end
                    default:
                    begin
                        if (count_reg < CNT_W'(2))
                        begin
                            fin        = 1'b1;
                            fin_status = rpn_pkg::ST_FEW;
                        end
                        else
                        begin
                            ram_re     = 1'b1;
                            ram_raddr  = ADDR_W'(count_reg - CNT_W'(1));
                            state_next = rpn_pkg::S_FETCH_R;
                        end
                    end
                endcase
            end

            rpn_pkg::S_FETCH_R:
            begin
                case (cmd_reg.opcode)
                    rpn_pkg::OP_POP, rpn_pkg::OP_PEEK_TOP, rpn_pkg::OP_PEEK_BOT:
                    begin
                        fin       = 1'b1;
                        fin_value = ram_rdata;
                        if (res_free && cmd_reg.opcode == rpn_pkg::OP_POP)
                        begin
                            count_next = count_reg - CNT_W'(1);
                        end
                    end
                    default:
                    begin
                        if (cmd_reg.opcode == rpn_pkg::OP_DIV && ram_rdata == '0)
                        begin
                            fin        = 1'b1;
                            fin_status = rpn_pkg::ST_DIVZERO;
                        end
                        else
                        begin
                            sign_r_next = ram_rdata[DW-1];
                            add_b       = {1'b0, ram_rdata};
                            add_sub     = 1'b1;
                            right_next  = (cmd_reg.opcode == rpn_pkg::OP_DIV
                                           && ram_rdata[DW-1]) ? add_sum[DW-1:0] : ram_rdata;
                            ram_re      = 1'b1;
                            ram_raddr   = ADDR_W'(count_reg - CNT_W'(2));
                            state_next  = rpn_pkg::S_FETCH_L;
                        end
                    end
                endcase
            end

            rpn_pkg::S_FETCH_L:
            begin
                sign_l_next = ram_rdata[DW-1];
                iter_next   = '0;
                case (cmd_reg.opcode)
                    rpn_pkg::OP_ADD, rpn_pkg::OP_SUB:
                    begin
                        add_a      = {1'b0, ram_rdata};
                        add_b      = {1'b0, right_reg};
                        add_sub    = (cmd_reg.opcode == rpn_pkg::OP_SUB);
                        acc_next   = add_sum[DW-1:0];
                        state_next = rpn_pkg::S_WB;
                    end
                    rpn_pkg::OP_MUL:
                    begin
                        left_next  = ram_rdata;
                        acc_next   = '0;
                        state_next = rpn_pkg::S_MUL;
                    end
                    default:
                    begin
                        add_b      = {1'b0, ram_rdata};
                        add_sub    = 1'b1;
                        left_next  = ram_rdata[DW-1] ? add_sum[DW-1:0] : ram_rdata;
                        acc_next   = '0;
                        state_next = rpn_pkg::S_DIV;
                    end
                endcase
            end

            rpn_pkg::S_MUL:
            begin
                add_a      = {1'b0, acc_reg};
                add_b      = {1'b0, left_reg};
                if (right_reg[0])
                begin
                    acc_next = add_sum[DW-1:0];
                end
                left_next  = {left_reg[DW-2:0], 1'b0};
                right_next = {1'b0, right_reg[DW-1:1]};
                iter_next  = iter_reg + rpn_pkg::ITER_W'(1);
                if (iter_reg == rpn_pkg::ITER_W'(DW - 1))
                begin
                    state_next = rpn_pkg::S_WB;
                end
            end

            rpn_pkg::S_DIV:
            begin
                add_a   = div_shift;
                add_b   = {1'b0, right_reg};
                add_sub = 1'b1;
                if (add_sum[DW+1])
                begin
                    acc_next  = add_sum[DW-1:0];
                    left_next = {left_reg[DW-2:0], 1'b1};
                end
                else
                begin
                    acc_next  = div_shift[DW-1:0];
                    left_next = {left_reg[DW-2:0], 1'b0};
                end
                iter_next = iter_reg + rpn_pkg::ITER_W'(1);
                if (iter_reg == rpn_pkg::ITER_W'(DW - 1))
                begin
                    state_next = rpn_pkg::S_FIX;
                end
            end

            rpn_pkg::S_FIX:
            begin
                add_b   = {1'b0, left_reg};
                add_sub = 1'b1;
                if (sign_l_reg ^ sign_r_reg)
                begin
                    acc_next = (acc_reg != '0) ? ~left_reg : add_sum[DW-1:0];
                end
                else
                begin
                    acc_next = left_reg;
                end
                state_next = rpn_pkg::S_WB;
            end

            rpn_pkg::S_WB:
            begin
                fin       = 1'b1;
                fin_value = acc_reg;
                if (res_free)
                begin
                    ram_we     = 1'b1;
                    ram_waddr  = ADDR_W'(count_reg - CNT_W'(2));
                    ram_wdata  = acc_reg;
                    count_next = count_reg - CNT_W'(1);
                end
            end

            default:
            begin
                state_next = rpn_pkg::S_IDLE;
            end
        endcase

        if (res_ready)
        begin
            res_valid_next = 1'b0;
        end
        if (fin && res_free)
        begin
            res_next.result_value = fin_value;
            res_next.status       = fin_status;
            res_next.stack_count  = rpn_pkg::COUNT_W'(count_next);
            res_valid_next        = 1'b1;
            state_next            = rpn_pkg::S_IDLE;
        end
    end

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(STACK_DEPTH))
        else $error("stack count beyond depth");

    a_accept_decode: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd_valid && cmd_ready) |=> (state_reg == rpn_pkg::S_DECODE))
        else $error("accepted word did not start decoding");

    a_result_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (fin && res_free) |=> (res_valid && state_reg == rpn_pkg::S_IDLE))
        else $error("loaded result without returning to idle");

    a_error_keeps_count: assert property (@(posedge clk) disable iff (!rst_n)
        (fin && res_free && fin_status != rpn_pkg::ST_OK) |=> $stable(count_reg))
        else $error("failed operation changed the stack count");

endmodule
